[design/fps_pkg.sv]
package fps_pkg;

  // elapsed counter width, both counters saturate at all ones
  localparam int TIMER_BITS = 16;
  localparam int CFG_BITS   = 16;
  // common width for counter against register compares
  localparam int CMP_W      = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

  // register indexes on the configuration port
  localparam logic [7:0] REG_BURN     = 8'd0;
  localparam logic [7:0] REG_APOGEE   = 8'd1;
  localparam logic [7:0] REG_DEPLOY   = 8'd2;
  localparam logic [7:0] REG_RECOVERY = 8'd3;

  // register reset values
  localparam logic [CFG_BITS-1:0] BURN_RST     = 16'd3500;
  localparam logic [CFG_BITS-1:0] APOGEE_RST   = 16'd500;
  localparam logic [CFG_BITS-1:0] DEPLOY_RST   = 16'd500;
  localparam logic [CFG_BITS-1:0] RECOVERY_RST = 16'd5000;

  // item modes
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_CMD  = 1'b1;

  // phase codes as seen on the ports
  localparam logic [2:0] CODE_IDLE     = 3'd0;
  localparam logic [2:0] CODE_IGNITION = 3'd1;
  localparam logic [2:0] CODE_POWERED  = 3'd2;
  localparam logic [2:0] CODE_COASTING = 3'd3;
  localparam logic [2:0] CODE_APOGEE   = 3'd4;
  localparam logic [2:0] CODE_RECOVERY = 3'd5;
  localparam logic [2:0] CODE_LANDED   = 3'd6;

  // internal one-hot phase state
  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_IGNITION = 7'b0000010,
    PH_POWERED  = 7'b0000100,
    PH_COASTING = 7'b0001000,
    PH_APOGEE   = 7'b0010000,
    PH_RECOVERY = 7'b0100000,
    PH_LANDED   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic       mode;
    logic [2:0] requested_phase;
  } in_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       phase_changed;
    logic       command_rejected;
    logic       prep_chute;
    logic       deploy_chute;
    logic       flight_done;
  } out_t;

  function automatic logic [2:0] phase_code(input phase_t p);
    logic [2:0] c;
    unique case (p)
      PH_IDLE:     c = CODE_IDLE;
      PH_IGNITION: c = CODE_IGNITION;
      PH_POWERED:  c = CODE_POWERED;
      PH_COASTING: c = CODE_COASTING;
      PH_APOGEE:   c = CODE_APOGEE;
      PH_RECOVERY: c = CODE_RECOVERY;
      PH_LANDED:   c = CODE_LANDED;
      default:     c = CODE_IDLE;
    endcase
    return c;
  endfunction

  // code 7 has no phase; callers only use this after an allowed check
  function automatic phase_t phase_of(input logic [2:0] c);
    phase_t p;
    unique case (c)
      CODE_IDLE:     p = PH_IDLE;
      CODE_IGNITION: p = PH_IGNITION;
      CODE_POWERED:  p = PH_POWERED;
      CODE_COASTING: p = PH_COASTING;
      CODE_APOGEE:   p = PH_APOGEE;
      CODE_RECOVERY: p = PH_RECOVERY;
      CODE_LANDED:   p = PH_LANDED;
      default:       p = PH_IDLE;
    endcase
    return p;
  endfunction

  // commanded transition table
  function automatic logic allowed(input phase_t from, input logic [2:0] to);
    logic ok;
    unique case (from)
      PH_IDLE:     ok = (to == CODE_IGNITION) || (to == CODE_POWERED);
      PH_IGNITION: ok = (to == CODE_POWERED) || (to == CODE_IDLE);
      PH_POWERED:  ok = (to == CODE_COASTING);
      PH_COASTING: ok = (to == CODE_APOGEE);
      PH_APOGEE:   ok = (to == CODE_RECOVERY);
      PH_RECOVERY: ok = (to == CODE_LANDED);
      default:     ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    return (v == '1) ? v : v + TIMER_BITS'(1);
  endfunction

endpackage

[design/flight_phase_sequencer_core.sv]
// Flight-phase sequencer: each input beat is a millisecond tick or a phase command and
// yields exactly one result beat. All work happens in combinational next-state logic on the
// phase and counter registers, so a beat is accepted every clock; results go to an output
// register backed by a one-entry skid stage, and in_ready drops only while both are full.
// Configuration writes are always accepted (cfg_ready is always high); indexes above
// three are ignored. Elapsed counters are TIMER_BITS wide and saturate.
module flight_phase_sequencer_core
  import fps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_t                 in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_t                out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);

  logic [CFG_BITS-1:0] burn_r, apogee_r, deploy_r, recovery_r;

  phase_t                phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] ph_el_r, ph_el_nxt;
  logic [TIMER_BITS-1:0] ign_el_r, ign_el_nxt;
  logic                  ign_rec_r, ign_rec_nxt;
  logic                  chute_r, chute_nxt;
  logic                  done_r, done_nxt;
  out_t                  res;

  logic out_valid_r, skid_valid_r;
  out_t out_data_r, skid_data_r;
  logic in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burn_r     <= BURN_RST;
      apogee_r   <= APOGEE_RST;
      deploy_r   <= DEPLOY_RST;
      recovery_r <= RECOVERY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BURN:     burn_r     <= cfg_data;
        REG_APOGEE:   apogee_r   <= cfg_data;
        REG_DEPLOY:   deploy_r   <= cfg_data;
        REG_RECOVERY: recovery_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state and result for one beat
  always_comb begin
    logic [TIMER_BITS-1:0] ph_inc, ign_inc;
    phase_nxt   = phase_r;
    ph_el_nxt   = ph_el_r;
    ign_el_nxt  = ign_el_r;
    ign_rec_nxt = ign_rec_r;
    chute_nxt   = chute_r;
    done_nxt    = done_r;
    res         = '0;
    ph_inc      = sat_inc(ph_el_r);
    ign_inc     = ign_rec_r ? sat_inc(ign_el_r) : ign_el_r;

    if (in_data.mode == MODE_CMD) begin
      if (phase_code(phase_r) != in_data.requested_phase) begin
        // a command for idle drops the ignition record even when rejected
        if (in_data.requested_phase == CODE_IDLE) begin
          ign_rec_nxt = 1'b0;
          ign_el_nxt  = '0;
        end
        if (allowed(phase_r, in_data.requested_phase)) begin
          phase_nxt         = phase_of(in_data.requested_phase);
          ph_el_nxt         = '0;
          res.phase_changed = 1'b1;
          if ((in_data.requested_phase == CODE_IGNITION ||
               in_data.requested_phase == CODE_POWERED) && !ign_rec_r) begin
            ign_rec_nxt = 1'b1;
            ign_el_nxt  = '0;
          end
        end else begin
          res.command_rejected = 1'b1;
        end
      end
    end else begin
      // tick: counters advance, then timed checks on the advanced values
      ph_el_nxt  = ph_inc;
      ign_el_nxt = ign_inc;
      unique case (phase_r)
        PH_IDLE: res.prep_chute = 1'b1;
        PH_POWERED: begin
          if (!ign_rec_r || CMP_W'(ign_inc) >= CMP_W'(burn_r)) begin
            phase_nxt         = PH_COASTING;
            ph_el_nxt         = '0;
            res.phase_changed = 1'b1;
          end
        end
        PH_COASTING: begin
          if (CMP_W'(ph_inc) >= CMP_W'(apogee_r)) begin
            phase_nxt         = PH_APOGEE;
            ph_el_nxt         = '0;
            res.phase_changed = 1'b1;
          end
        end
        PH_APOGEE: begin
          if (CMP_W'(ph_inc) >= CMP_W'(deploy_r)) begin
            res.deploy_chute  = !chute_r;
            chute_nxt         = 1'b1;
            phase_nxt         = PH_RECOVERY;
            ph_el_nxt         = '0;
            res.phase_changed = 1'b1;
          end
        end
        PH_RECOVERY: begin
          if (CMP_W'(ph_inc) >= CMP_W'(recovery_r)) begin
            phase_nxt         = PH_LANDED;
            ph_el_nxt         = '0;
            res.phase_changed = 1'b1;
            done_nxt          = 1'b1;
          end
        end
        default: ;
      endcase
    end
    res.phase       = phase_code(phase_nxt);
    res.flight_done = done_nxt;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      ph_el_r   <= '0;
      ign_el_r  <= '0;
      ign_rec_r <= 1'b0;
      chute_r   <= 1'b0;
      done_r    <= 1'b0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      ph_el_r   <= ph_el_nxt;
      ign_el_r  <= ign_el_nxt;
      ign_rec_r <= ign_rec_nxt;
      chute_r   <= chute_nxt;
      done_r    <= done_nxt;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (in_fire) begin
      skid_data_r <= res;
    end
  end

`ifndef SYNTHESIS
  // skid stage only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full while output register empty");

  a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && in_fire) |=> skid_valid_r)
    else $error("beat accepted under stall was not caught by skid stage");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("done latch cleared");

  a_chute_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    chute_r |=> chute_r)
    else $error("chute latch cleared");

  a_ign_count_recorded: assert property (@(posedge clk) disable iff (!rst_n)
    (ign_el_r != '0) |-> ign_rec_r)
    else $error("ignition counter running without ignition record");
`endif

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import fps_pkg::*;

  // spare register indexes, writes there must be dropped
  localparam logic [7:0] REG_SPARE_LO = 8'd4;
  localparam logic [7:0] REG_SPARE_HI = 8'hFF;
  // requested phase code with no phase behind it
  localparam logic [2:0] CODE_UNUSED  = 3'd7;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLDOFF_BEATS = 300;
  localparam int IDLE_PCT      = 37;

  typedef enum logic [1:0] {REQ_IGNORED, REQ_TAKEN, REQ_REFUSED} req_result_t;

  // flight phase predictor plus queue of predicted result beats
  class phase_scoreboard;
    logic [2:0]            cur_phase;
    logic [TIMER_BITS-1:0] in_phase_ms;
    logic [TIMER_BITS-1:0] since_ign_ms;
    bit                    ign_rec;
    bit                    chute_out;
    bit                    done_flag;
    logic [CFG_BITS-1:0]   burn_ms;
    logic [CFG_BITS-1:0]   apogee_ms;
    logic [CFG_BITS-1:0]   deploy_ms;
    logic [CFG_BITS-1:0]   recovery_ms;
    out_t                  want_q[$];
    int                    errors;
    int                    n_beats_in;
    int                    n_beats_out;

    function new();
      cur_phase    = CODE_IDLE;
      in_phase_ms  = '0;
      since_ign_ms = '0;
      ign_rec      = 1'b0;
      chute_out    = 1'b0;
      done_flag    = 1'b0;
      burn_ms      = BURN_RST;
      apogee_ms    = APOGEE_RST;
      deploy_ms    = DEPLOY_RST;
      recovery_ms  = RECOVERY_RST;
      errors       = 0;
      n_beats_in   = 0;
      n_beats_out  = 0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [CFG_BITS-1:0] val);
      case (idx)
        REG_BURN:     burn_ms = val;
        REG_APOGEE:   apogee_ms = val;
        REG_DEPLOY:   deploy_ms = val;
        REG_RECOVERY: recovery_ms = val;
        default: ;
      endcase
    endfunction

    // commanded moves that the sequencer accepts
    function bit transition_ok(logic [2:0] from, logic [2:0] to);
      case (from)
        CODE_IDLE:     return to == CODE_IGNITION || to == CODE_POWERED;
        CODE_IGNITION: return to == CODE_POWERED || to == CODE_IDLE;
        CODE_POWERED:  return to == CODE_COASTING;
        CODE_COASTING: return to == CODE_APOGEE;
        CODE_APOGEE:   return to == CODE_RECOVERY;
        CODE_RECOVERY: return to == CODE_LANDED;
        default:       return 1'b0;
      endcase
    endfunction

    function logic [TIMER_BITS-1:0] bump(logic [TIMER_BITS-1:0] v);
      return (&v) ? v : v + TIMER_BITS'(1);
    endfunction

    function bit reached(logic [TIMER_BITS-1:0] t, logic [CFG_BITS-1:0] lim);
      return 64'(t) >= 64'(lim);
    endfunction

    // idle request drops the ignition record even when refused
    function req_result_t request(logic [2:0] to);
      if (to == cur_phase) return REQ_IGNORED;
      if (to == CODE_IDLE) begin
        ign_rec      = 1'b0;
        since_ign_ms = '0;
      end
      if (!transition_ok(cur_phase, to)) return REQ_REFUSED;
      cur_phase   = to;
      in_phase_ms = '0;
      if ((to == CODE_IGNITION || to == CODE_POWERED) && !ign_rec) begin
        ign_rec      = 1'b1;
        since_ign_ms = '0;
      end
      return REQ_TAKEN;
    endfunction

    // advance the model by one accepted input beat
    function void note_input(in_t it);
      out_t        o;
      req_result_t r;
      o = '0;
      if (it.mode == MODE_CMD) begin
        r = request(it.requested_phase);
        o.phase_changed    = (r == REQ_TAKEN);
        o.command_rejected = (r == REQ_REFUSED);
      end else begin
        in_phase_ms = bump(in_phase_ms);
        if (ign_rec) since_ign_ms = bump(since_ign_ms);
        case (cur_phase)
          CODE_IDLE: o.prep_chute = 1'b1;
          // no ignition record means burnout is due right away
          CODE_POWERED:
            if (!ign_rec || reached(since_ign_ms, burn_ms))
              o.phase_changed = (request(CODE_COASTING) == REQ_TAKEN);
          CODE_COASTING:
            if (reached(in_phase_ms, apogee_ms))
              o.phase_changed = (request(CODE_APOGEE) == REQ_TAKEN);
          CODE_APOGEE:
            if (reached(in_phase_ms, deploy_ms)) begin
              if (!chute_out) begin
                chute_out      = 1'b1;
                o.deploy_chute = 1'b1;
              end
              o.phase_changed = (request(CODE_RECOVERY) == REQ_TAKEN);
            end
          CODE_RECOVERY:
            if (reached(in_phase_ms, recovery_ms)) begin
              o.phase_changed = (request(CODE_LANDED) == REQ_TAKEN);
              done_flag = 1'b1;
            end
          default: ;
        endcase
      end
      o.phase       = cur_phase;
      o.flight_done = done_flag;
      want_q.push_back(o);
      n_beats_in++;
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH %s", msg);
    endtask

    task compare_field(string name, logic [2:0] got, logic [2:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0d, want %0d", n_beats_out, name, got, want));
    endtask

    // compare one result beat against the oldest prediction
    task check_result(out_t got);
      out_t want;
      n_beats_out++;
      if (want_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing predicted", n_beats_out));
        return;
      end
      want = want_q.pop_front();
      compare_field("phase", got.phase, want.phase);
      compare_field("phase_changed", 3'(got.phase_changed), 3'(want.phase_changed));
      compare_field("command_rejected", 3'(got.command_rejected),
                    3'(want.command_rejected));
      compare_field("prep_chute", 3'(got.prep_chute), 3'(want.prep_chute));
      compare_field("deploy_chute", 3'(got.deploy_chute), 3'(want.deploy_chute));
      compare_field("flight_done", 3'(got.flight_done), 3'(want.flight_done));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_data;
  logic                out_valid;
  logic                out_ready;
  out_t                out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [7:0]          cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  phase_scoreboard sb = new();
  bit quiet;
  bit hold_req;
  int n_reg_writes;
  int idle_run = 0;

  flight_phase_sequencer_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // watchdog on cycles where no channel moves a beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_run = 0;
      else
        idle_run++;
      if (idle_run >= STALL_LIMIT) begin
        $display("stalled for %0d cycles", idle_run);
        $display("flight_phase_sequencer_core test failed");
        $finish;
      end
    end
  end

  // result side: random back-pressure plus one long hold-off
  initial begin
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLDOFF_BEATS;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task send_item(in_t it);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  task send_beat(logic mode, logic [2:0] req);
    in_t it;
    it.mode            = mode;
    it.requested_phase = req;
    send_item(it);
  endtask

  // wait until every predicted result has come back
  task drain();
    in_valid <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk);
  endtask

  task write_reg(logic [7:0] idx, logic [CFG_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    n_reg_writes++;
  endtask

  task set_regs(logic [CFG_BITS-1:0] b, logic [CFG_BITS-1:0] a,
                logic [CFG_BITS-1:0] d, logic [CFG_BITS-1:0] r, bit spare);
    drain();
    write_reg(REG_BURN, b);
    write_reg(REG_APOGEE, a);
    write_reg(REG_DEPLOY, d);
    write_reg(REG_RECOVERY, r);
    if (spare) begin
      write_reg(REG_SPARE_LO, CFG_BITS'($urandom));
      write_reg(REG_SPARE_HI, CFG_BITS'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  // threshold either zero or a little past the running count
  function automatic logic [CFG_BITS-1:0] near(logic [TIMER_BITS-1:0] t);
    if ($urandom_range(2) == 0) return '0;
    return CFG_BITS'(t) + CFG_BITS'($urandom_range(20, 1));
  endfunction

  // random beat; keeps the flight on the ground or inside its phase as asked
  function automatic in_t pick_item(int cmd_pct, bit preflight, bit hold);
    in_t        it;
    logic [2:0] req;
    logic [2:0] cur;
    cur                = sb.cur_phase;
    it.mode            = MODE_TICK;
    it.requested_phase = 3'($urandom_range(7));
    if ($urandom_range(99) < cmd_pct) begin
      req = 3'($urandom_range(7));
      if (preflight && req == CODE_POWERED) req = CODE_IGNITION;
      // deployment and landing must come from the timers
      if ((cur == CODE_APOGEE && req == CODE_RECOVERY) ||
          (cur == CODE_RECOVERY && req == CODE_LANDED))
        req = cur;
      if (hold && (req == CODE_IDLE || sb.transition_ok(cur, req))) req = cur;
      it.mode            = MODE_CMD;
      it.requested_phase = req;
    end
    return it;
  endfunction

  task run_items(int count, int cmd_pct, bit preflight, bit hold, bit stop_on_change);
    logic [2:0] start_phase;
    start_phase = sb.cur_phase;
    for (int k = 0; k < count; k++) begin
      send_item(pick_item(cmd_pct, preflight, hold));
      if (stop_on_change && sb.cur_phase != start_phase) break;
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    n_reg_writes = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed ground checks with reset registers
    send_beat(MODE_TICK, CODE_IDLE);
    send_beat(MODE_CMD, CODE_UNUSED);
    send_beat(MODE_CMD, CODE_IDLE);
    send_beat(MODE_CMD, CODE_COASTING);
    send_beat(MODE_CMD, CODE_LANDED);
    send_beat(MODE_CMD, CODE_IGNITION);
    send_beat(MODE_CMD, CODE_IGNITION);
    send_beat(MODE_TICK, CODE_UNUSED);
    send_beat(MODE_TICK, CODE_IDLE);
    send_beat(MODE_CMD, CODE_RECOVERY);
    send_beat(MODE_CMD, CODE_UNUSED);
    send_beat(MODE_CMD, CODE_IDLE);
    send_beat(MODE_TICK, CODE_IDLE);
    send_beat(MODE_CMD, CODE_IGNITION);
    send_beat(MODE_CMD, CODE_APOGEE);
    send_beat(MODE_CMD, CODE_IDLE);

    // ground random traffic across register settings, with one long hold-off
    set_regs('0, '0, '0, '0, 1'b1);
    hold_req = 1'b1;
    run_items(500, 40, 1'b1, 1'b0, 1'b0);
    set_regs(CFG_BITS'($urandom), CFG_BITS'($urandom), CFG_BITS'($urandom),
             CFG_BITS'($urandom), 1'b1);
    run_items(500, 40, 1'b1, 1'b0, 1'b0);
    quiet = 1'b1;
    set_regs('1, '1, '1, '1, 1'b0);
    run_items(300, 40, 1'b1, 1'b0, 1'b0);
    quiet = 1'b0;

    // launch, either straight from idle or through ignition
    send_beat(MODE_CMD, CODE_IDLE);
    if ($urandom_range(1)) send_beat(MODE_CMD, CODE_IGNITION);
    send_beat(MODE_CMD, CODE_POWERED);

    // powered: hold, then arm burnout
    run_items(200, 15, 1'b0, 1'b1, 1'b0);
    set_regs(near(sb.since_ign_ms), '1, '1, '1, 1'b0);
    run_items(2000, 25, 1'b0, 1'b0, 1'b1);

    // coasting: hold, then arm apogee
    run_items(100, 15, 1'b0, 1'b1, 1'b0);
    set_regs(sb.burn_ms, near(sb.in_phase_ms), '1, '1, 1'b0);
    run_items(2000, 25, 1'b0, 1'b0, 1'b1);

    // apogee: hold, then arm deployment
    run_items(100, 15, 1'b0, 1'b1, 1'b0);
    set_regs(sb.burn_ms, sb.apogee_ms, near(sb.in_phase_ms), '1, 1'b0);
    run_items(2000, 25, 1'b0, 1'b0, 1'b1);

    // recovery: arm landing
    set_regs(sb.burn_ms, sb.apogee_ms, sb.deploy_ms, near(sb.in_phase_ms), 1'b0);
    run_items(2000, 25, 1'b0, 1'b0, 1'b1);

    // landed: everything from here on is inert
    run_items(100, 40, 1'b0, 1'b0, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    $display("%0d input beats, %0d result beats, %0d register writes, %0d mismatches",
             sb.n_beats_in, sb.n_beats_out, n_reg_writes, sb.errors);
    $display("ground traffic, one full flight to phase %0d, chute %0b, done %0b",
             sb.cur_phase, sb.chute_out, sb.done_flag);
    if (sb.errors == 0 && sb.want_q.size() == 0)
      $display("flight_phase_sequencer_core test passed");
    else
      $display("flight_phase_sequencer_core test failed");
    $finish;
  end

endmodule

[sim.f]
design/fps_pkg.sv
design/flight_phase_sequencer_core.sv
tb/sv/testbench.sv
